@@ design/pqa_pkg.sv @@
// ----------------------------------------------------------------------------
// pqa_pkg
// Shared sizes, types, status codes and controller/datapath interface
// structs for the priority queue with aging.
// ----------------------------------------------------------------------------
package pqa_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TOP_PRIORITY = 255;
  localparam int ID_BITS      = 10;
  localparam int PRIO_W       = 8;
  localparam int IDX_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [PRIO_W-1:0]  prio_t;
  typedef logic [1:0]         status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_BADPRIO = 2'd3;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_RETRIEVE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;       // capture the transaction
    logic    ins_rd;     // read the slot in front of the tail
    logic    ins_shift;  // move the read entry back one slot
    logic    ins_put;    // place the new entry
    logic    ret_rd;     // read the head slot
    logic    ret_take;   // remove the head
    logic    age_step;   // age one remaining entry
    logic    st_wr;      // record a status code
    status_t st_code;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_retrieve;
    logic prio_bad;
    logic full;
    logic empty;
    logic gt;            // read priority strictly above the new one
    logic prev_is_head;  // slot in front of pos is the head
    logic take_last;     // head is the only entry
    logic age_last;      // last entry to age
  } dp_stat_t;

  function automatic idx_t idx_inc(idx_t i);
    idx_t r;
    if (i == idx_t'(QUEUE_DEPTH - 1)) r = '0;
    else r = i + idx_t'(1);
    return r;
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    idx_t r;
    if (i == '0) r = idx_t'(QUEUE_DEPTH - 1);
    else r = i - idx_t'(1);
    return r;
  endfunction

endpackage

@@ design/pqa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pqa_ctrl
// Sequencer for insert and retrieve transactions: issues datapath commands
// and marks the result cycle.
// ----------------------------------------------------------------------------
module pqa_ctrl
  import pqa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_valid
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_TAKE    = 3'd4;
  localparam logic [2:0] S_AGE     = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.is_retrieve) begin
          priority if (stat.prio_bad) begin
            cmd.st_wr   = 1'b1;
            cmd.st_code = ST_BADPRIO;
            state_nxt   = S_DONE;
          end else if (stat.full) begin
            cmd.st_wr   = 1'b1;
            cmd.st_code = ST_FULL;
            state_nxt   = S_DONE;
          end else if (stat.empty) begin
            state_nxt = S_INS_PUT;
          end else begin
            cmd.ins_rd = 1'b1;
            state_nxt  = S_INS_CMP;
          end
        end else begin
          if (stat.empty) begin
            cmd.st_wr   = 1'b1;
            cmd.st_code = ST_EMPTY;
            state_nxt   = S_DONE;
          end else begin
            cmd.ret_rd = 1'b1;
            state_nxt  = S_TAKE;
          end
        end
      end
      S_INS_CMP: begin
        if (stat.gt) begin
          cmd.ins_shift = 1'b1;
          // reached the head: the new entry goes there
          if (stat.prev_is_head) state_nxt = S_INS_PUT;
        end else begin
          cmd.ins_put = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_nxt   = S_DONE;
      end
      S_TAKE: begin
        cmd.ret_take = 1'b1;
        state_nxt    = stat.take_last ? S_DONE : S_AGE;
      end
      S_AGE: begin
        cmd.age_step = 1'b1;
        if (stat.age_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

@@ design/pqa_dp.sv @@
// ----------------------------------------------------------------------------
// pqa_dp
// Slot memories, ring pointers, entry count and result registers of the
// priority queue with aging.
// ----------------------------------------------------------------------------
module pqa_dp
  import pqa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  input  logic     in_command,
  input  id_t      in_entry_id,
  input  prio_t    in_entry_priority,
  output dp_stat_t stat,
  output status_t  status_q,
  output id_t      served_q,
  output cnt_t     count_q
);

  id_t   ids_mem   [QUEUE_DEPTH];
  prio_t prios_mem [QUEUE_DEPTH];

  logic    item_cmd_r;
  id_t     item_id_r;
  prio_t   item_prio_r;
  idx_t    head_r, tail_r, pos_r, age_addr_r;
  cnt_t    count_r, age_left_r;
  id_t     rd_id_r, served_r;
  prio_t   rd_prio_r, aged_prio;
  status_t status_r;
  idx_t    rd_addr;
  idx_t    pos_prev;

  assign pos_prev  = idx_dec(pos_r);
  assign aged_prio = (rd_prio_r > prio_t'(1)) ? rd_prio_r - prio_t'(1) : rd_prio_r;

  // Read address for the entry needed next cycle
  always_comb begin
    priority if (cmd.ins_rd)    rd_addr = idx_dec(tail_r);
    else if (cmd.ins_shift)     rd_addr = idx_dec(pos_prev);
    else if (cmd.ret_rd)        rd_addr = head_r;
    else if (cmd.ret_take)      rd_addr = idx_inc(head_r);
    else if (cmd.age_step)      rd_addr = idx_inc(age_addr_r);
    else                        rd_addr = head_r;
  end

  always_ff @(posedge clk) begin
    rd_id_r   <= ids_mem[rd_addr];
    rd_prio_r <= prios_mem[rd_addr];
    if (cmd.ins_shift) begin
      ids_mem[pos_r]   <= rd_id_r;
      prios_mem[pos_r] <= rd_prio_r;
    end else if (cmd.ins_put) begin
      ids_mem[pos_r]   <= item_id_r;
      prios_mem[pos_r] <= item_prio_r;
    end else if (cmd.age_step) begin
      prios_mem[age_addr_r] <= aged_prio;
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd_r  <= in_command;
      item_id_r   <= in_entry_id;
      item_prio_r <= in_entry_priority;
      pos_r       <= tail_r;
      served_r    <= '0;
      status_r    <= ST_OK;
    end else begin
      if (cmd.ins_shift) pos_r <= pos_prev;
      if (cmd.st_wr) status_r <= cmd.st_code;
      if (cmd.ret_take) served_r <= rd_id_r;
    end
    if (cmd.ret_take) begin
      age_addr_r <= idx_inc(head_r);
      age_left_r <= count_r - cnt_t'(1);
    end else if (cmd.age_step) begin
      age_addr_r <= idx_inc(age_addr_r);
      age_left_r <= age_left_r - cnt_t'(1);
    end
  end

  // Ring pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.ins_put) begin
      tail_r  <= idx_inc(tail_r);
      count_r <= count_r + cnt_t'(1);
    end else if (cmd.ret_take) begin
      head_r  <= idx_inc(head_r);
      count_r <= count_r - cnt_t'(1);
    end
  end

  always_comb begin
    stat.is_retrieve  = (item_cmd_r == CMD_RETRIEVE);
    stat.prio_bad     = (item_prio_r == '0) || (int'(item_prio_r) > TOP_PRIORITY);
    stat.full         = (count_r == cnt_t'(QUEUE_DEPTH));
    stat.empty        = (count_r == '0);
    stat.gt           = (rd_prio_r > item_prio_r);
    stat.prev_is_head = (pos_prev == head_r);
    stat.take_last    = (count_r == cnt_t'(1));
    stat.age_last     = (age_left_r == cnt_t'(1));
  end

  assign status_q = status_r;
  assign served_q = served_r;
  assign count_q  = count_r;

endmodule

@@ design/priority_queue_with_aging.sv @@
// ----------------------------------------------------------------------------
// priority_queue_with_aging
// Sorted ring of (id, priority) entries: insert shifts larger numbers back,
// retrieve serves the head and ages the rest down to a floor of 1.
// ----------------------------------------------------------------------------
// Accept to result strobe: a rejected transaction goes from the decision to
// the result state; an insert moves k entries back (one slot per cycle) and
// places the new one; a retrieve takes the head and ages the n entries left
// (one slot per cycle, the pace of the one-read, one-write slot memory port).
// busy stays high through the result cycle: no new transaction until then.
// Synchronous reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module priority_queue_with_aging
  import pqa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  logic    in_command,
  input  id_t     in_entry_id,
  input  prio_t   in_entry_priority,
  output logic    out_valid,
  output status_t out_status,
  output id_t     out_served_id,
  output cnt_t    out_occupancy
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pqa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pqa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_command        (in_command),
    .in_entry_id       (in_entry_id),
    .in_entry_priority (in_entry_priority),
    .stat              (stat),
    .status_q          (out_status),
    .served_q          (out_served_id),
    .count_q           (out_occupancy)
  );

endmodule

@@ verif/priority_queue_with_aging_test.sv @@
// ----------------------------------------------------------------------------
// priority_queue_with_aging_test
// Drives insert and retrieve transactions into the sorted aging queue and
// checks every result strobe against an in-bench model of the ring. A short
// directed pass is followed by biased random traffic, with random start gaps.
// ----------------------------------------------------------------------------
module priority_queue_with_aging_test
  import pqa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t status;
    id_t     served_id;
    cnt_t    occupancy;
  } outcome_t;

  logic    clk               = 1'b0;
  logic    rst_n             = 1'b0;
  logic    start             = 1'b0;
  logic    in_command        = CMD_INSERT;
  id_t     in_entry_id       = '0;
  prio_t   in_entry_priority = '0;
  logic    busy;
  logic    out_valid;
  status_t out_status;
  id_t     out_served_id;
  cnt_t    out_occupancy;

  // Ring model: ids and priorities, head, tail and fill level
  id_t   ring_id   [QUEUE_DEPTH];
  prio_t ring_prio [QUEUE_DEPTH];
  int    ring_head  = 0;
  int    ring_tail  = 0;
  int    ring_count = 0;

  outcome_t pending_outcomes[$];
  int       fail_count = 0;
  bit       gaps_on    = 1'b1;

  priority_queue_with_aging u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_entry_id       (in_entry_id),
    .in_entry_priority (in_entry_priority),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_served_id     (out_served_id),
    .out_occupancy     (out_occupancy)
  );

  always #6 clk = ~clk;

  function automatic outcome_t queue_outcome(logic cmd, id_t id, prio_t prio);
    outcome_t res;
    int       pos;
    int       prev;
    res.status    = ST_OK;
    res.served_id = '0;
    if (cmd == CMD_INSERT) begin
      if (prio == 0 || int'(prio) > TOP_PRIORITY) begin
        res.status = ST_BADPRIO;
      end else if (ring_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos  = ring_tail;
        prev = (pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        // move strictly larger numbers back one slot; equal ones stay in front
        while (pos != ring_head && ring_prio[prev] > prio) begin
          ring_id[pos]   = ring_id[prev];
          ring_prio[pos] = ring_prio[prev];
          pos  = prev;
          prev = (pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        end
        ring_id[pos]   = id;
        ring_prio[pos] = prio;
        ring_tail  = (ring_tail + 1) % QUEUE_DEPTH;
        ring_count = ring_count + 1;
      end
    end else begin
      if (ring_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.served_id = ring_id[ring_head];
        ring_head  = (ring_head + 1) % QUEUE_DEPTH;
        ring_count = ring_count - 1;
        pos = ring_head;
        // age the remaining entries, floor of 1
        for (int k = 0; k < ring_count; k++) begin
          if (ring_prio[pos] > 1) ring_prio[pos] = ring_prio[pos] - 1'b1;
          pos = (pos + 1) % QUEUE_DEPTH;
        end
      end
    end
    res.occupancy = cnt_t'(ring_count);
    return res;
  endfunction

  // Offer one transaction; it is taken at the first rising edge with busy low
  task automatic send_item(logic cmd, id_t id, prio_t prio);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      gap = $urandom_range(1, 20);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start             <= 1'b1;
    in_command        <= cmd;
    in_entry_id       <= id;
    in_entry_priority <= prio;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_outcomes.push_back(queue_outcome(cmd, id, prio));
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_served_id !== want.served_id) begin
          $error("served_id mismatch: expected %0d, actual %0d",
                 want.served_id, out_served_id);
          fail_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("occupancy mismatch: expected %0d, actual %0d",
                 want.occupancy, out_occupancy);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    // empty retrieve, with the ignored fields at their top values
    send_item(CMD_RETRIEVE, id_t'(1023), prio_t'(255));
    send_item(CMD_INSERT, id_t'(5), prio_t'(0));
    send_item(CMD_INSERT, id_t'(1023), prio_t'(255));
    send_item(CMD_INSERT, id_t'(0), prio_t'(1));
    // equal priorities must leave in arrival order
    for (int k = 0; k < 3; k++) send_item(CMD_INSERT, id_t'(100 + k), prio_t'(7));
    for (int k = 0; k < 11; k++) begin
      send_item(CMD_INSERT, id_t'(200 + k), prio_t'((k * 23) % 255 + 1));
    end
    send_item(CMD_INSERT, id_t'(777), prio_t'(3));
    // bad priority is reported ahead of full
    send_item(CMD_INSERT, id_t'(778), prio_t'(0));
    for (int k = 0; k < 4; k++) send_item(CMD_RETRIEVE, '0, '0);
  endtask

  task automatic random_item(int insert_pct);
    int    pick;
    prio_t prio;
    pick = $urandom_range(0, 99);
    if (pick < 3)       prio = '0;
    else if (pick < 40) prio = prio_t'($urandom_range(1, 4));
    else                prio = prio_t'($urandom_range(1, TOP_PRIORITY));
    send_item(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_RETRIEVE,
              id_t'($urandom_range(0, 1023)), prio);
  endtask

  task automatic test_random_traffic(int n_items);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      // swing the mix so the ring runs full and empty in turn
      if (i % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      random_item(insert_pct);
    end
  endtask

  task automatic test_back_to_back(int n_items);
    gaps_on = 1'b0;
    for (int i = 0; i < n_items; i++) random_item(i < n_items / 2 ? 80 : 30);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain();
    while (ring_count > 0) send_item(CMD_RETRIEVE, id_t'($urandom_range(0, 1023)), '0);
    send_item(CMD_RETRIEVE, '0, '0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(1700);
    test_back_to_back(300);
    test_drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_outcomes.size() == 0);
    repeat (25) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule
